>>> rtl/core/tfp6_pkg.sv
// ---------------------------------------------------------------------------
// tfp6_pkg
// Shared types and constants for the 6-bit text frame parser.
// ---------------------------------------------------------------------------
package tfp6_pkg;

    // frame type bytes
    localparam logic [7:0] TYPE_TEXT = 8'h01;
    localparam logic [7:0] TYPE_ACK  = 8'h02;

    // largest accepted character count
    localparam logic [7:0] MAX_CHARS = 8'd50;

    // mask of one character code
    localparam logic [5:0] CODE_MASK = 6'h3F;

    // most character items one byte can complete
    localparam int CHARS_PER_BYTE = 2;

    // most result items one byte can cause
    localparam int SLOTS = CHARS_PER_BYTE + 1;

    // frame status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNKNOWN     = 3'd1;
    localparam logic [2:0] ST_SHORT       = 3'd2;
    localparam logic [2:0] ST_COUNT_LARGE = 3'd3;
    localparam logic [2:0] ST_PACKED_SHORT = 3'd4;

    // result kinds
    localparam logic RES_CHAR = 1'b0;
    localparam logic RES_END  = 1'b1;

    // message kinds
    localparam logic MSG_TEXT = 1'b0;
    localparam logic MSG_ACK  = 1'b1;

    // frame type seen in the first byte
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    // input item
    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_end;
    } t_in_item;

    // result item
    typedef struct packed {
        logic               item_kind;
        logic [5:0]         char_code;
        logic [5:0]         char_position;
        logic [2:0]         frame_status;
        logic               message_kind;
        logic [7:0]         sequence_res;
        logic [7:0]         char_total;
        logic               gps_present;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic               last_of_run;
    } t_out_item;

endpackage

>>> rtl/core/text_frame_parser_6bit.sv
// ---------------------------------------------------------------------------
// text_frame_parser_6bit
// Results of an accepted byte are registered and appear in the next cycle.
// Throughput: one byte per cycle while each byte causes at most one result and
// the output is not stalled; a byte with up to 3 results holds the input until
// its last is taken from the single-read buffer, one item per unstalled cycle.
// Reset (synchronous, active low) clears the frame state and pending results.
// ---------------------------------------------------------------------------
module text_frame_parser_6bit
    import tfp6_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // frame state
    logic [8:0]  r_byte_pos;
    t_kind       r_kind;
    logic [7:0]  r_seq;
    logic [7:0]  r_count;
    logic [7:0]  r_plen;
    logic [3:0]  r_residue;
    logic [2:0]  r_res_bits;
    logic [7:0]  r_chars_done;
    logic        r_gps_flag;
    logic [31:0] r_lat;
    logic [31:0] r_lon;
    logic        r_count_err;

    logic [8:0]  n_byte_pos;
    t_kind       n_kind;
    logic [7:0]  n_seq;
    logic [7:0]  n_count;
    logic [7:0]  n_plen;
    logic [3:0]  n_residue;
    logic [2:0]  n_res_bits;
    logic [7:0]  n_chars_done;
    logic        n_gps_flag;
    logic [31:0] n_lat;
    logic [31:0] n_lon;
    logic        n_count_err;

    // result buffer
    t_out_item   r_slot [SLOTS];
    logic [1:0]  r_cnt;
    t_out_item   n_slot [SLOTS];
    logic [1:0]  n_cnt;

    logic accept;
    logic pop;

    // handshake
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_slot[0];
    assign pop         = o_out_valid && !i_out_stall;
    assign o_in_stall  = !((r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_out_stall));
    assign accept      = i_in_valid && !o_in_stall;

    // byte decode, character extraction and end-of-frame status
    always_comb begin
        logic [7:0]  b;
        logic [9:0]  p;
        logic [9:0]  len;
        logic [9:0]  plen_x;
        logic [11:0] acc;
        logic [3:0]  nb;
        logic [3:0]  sh;
        logic [7:0]  done;
        logic [1:0]  nc;
        logic [9:0]  k_off;
        logic [2:0]  k;
        logic        gps_ok;
        t_out_item   end_item;

        b      = i_in_item.byte_value;
        p      = {1'b0, r_byte_pos};
        len    = p + 10'd1;
        plen_x = {2'b00, r_plen};
        acc    = {r_residue, b};
        nb     = {1'b0, r_res_bits} + 4'd8;
        done   = r_chars_done;
        nc     = 2'd0;
        sh     = 4'd0;
        k_off  = 10'd0;
        k      = 3'd0;
        gps_ok = 1'b0;

        n_byte_pos   = (r_byte_pos != 9'h1FF) ? r_byte_pos + 9'd1 : r_byte_pos;
        n_kind       = r_kind;
        n_seq        = r_seq;
        n_count      = r_count;
        n_plen       = r_plen;
        n_residue    = r_residue;
        n_res_bits   = r_res_bits;
        n_chars_done = r_chars_done;
        n_gps_flag   = r_gps_flag;
        n_lat        = r_lat;
        n_lon        = r_lon;
        n_count_err  = r_count_err;

        for (int i = 0; i < SLOTS; i++) begin
            n_slot[i] = '0;
        end

        // field capture by position
        if (p == 10'd0) begin
            if (b == TYPE_TEXT) begin
                n_kind = KIND_TEXT;
            end else if (b == TYPE_ACK) begin
                n_kind = KIND_ACK;
            end else begin
                n_kind = KIND_UNKNOWN;
            end
        end else if (r_kind == KIND_ACK) begin
            if (p == 10'd1) begin
                n_seq = b;
            end
        end else if (r_kind == KIND_TEXT) begin
            if (p == 10'd1) begin
                n_seq = b;
            end else if (p == 10'd2) begin
                n_count     = b;
                n_count_err = (b > MAX_CHARS);
            end else if (p == 10'd3) begin
                n_plen = b;
            end else if (p < 10'd4 + plen_x) begin
                // unpack 6-bit codes, most significant bit first
                if (!r_count_err) begin
                    for (int c = 0; c < CHARS_PER_BYTE; c++) begin
                        if (nb >= 4'd6 && done < r_count) begin
                            sh = nb - 4'd6;
                            n_slot[c].item_kind     = RES_CHAR;
                            n_slot[c].char_code     = 6'(acc >> sh) & CODE_MASK;
                            n_slot[c].char_position = done[5:0];
                            n_slot[c].message_kind  = MSG_TEXT;
                            n_slot[c].sequence_res  = r_seq;
                            n_slot[c].char_total    = r_count;
                            done = done + 8'd1;
                            nb   = nb - 4'd6;
                            nc   = nc + 2'd1;
                        end
                    end
                    n_chars_done = done;
                    if (nb < 4'd6) begin
                        n_residue  = 4'(acc & ((12'd1 << nb) - 12'd1));
                        n_res_bits = nb[2:0];
                    end else begin
                        n_residue  = 4'd0;
                        n_res_bits = 3'd0;
                    end
                end
            end else if (p == 10'd4 + plen_x) begin
                n_gps_flag = (b != 8'd0);
            end else if (p < 10'd13 + plen_x) begin
                // little-endian coordinate bytes
                k_off = p - (10'd5 + plen_x);
                k     = k_off[2:0];
                if (!k[2]) begin
                    n_lat[{k[1:0], 3'b000} +: 8] = r_lat[{k[1:0], 3'b000} +: 8] | b;
                end else begin
                    n_lon[{k[1:0], 3'b000} +: 8] = r_lon[{k[1:0], 3'b000} +: 8] | b;
                end
            end
        end

        // end-of-frame result from the updated state
        end_item           = '0;
        end_item.item_kind = RES_END;
        case (n_kind)
            KIND_TEXT: begin
                end_item.message_kind = MSG_TEXT;
                end_item.sequence_res = (len >= 10'd2) ? n_seq : 8'd0;
                end_item.char_total   = (len >= 10'd3) ? n_count : 8'd0;
                gps_ok = (len >= 10'd5 + plen_x) && (len >= 10'd4) && n_gps_flag;
                end_item.gps_present  = gps_ok;
                if (len < 10'd4 || len < 10'd5 + plen_x) begin
                    end_item.frame_status = ST_SHORT;
                end else if (n_count_err) begin
                    end_item.frame_status = ST_COUNT_LARGE;
                end else if (n_chars_done < n_count) begin
                    end_item.frame_status = ST_PACKED_SHORT;
                end else if (n_gps_flag && len < 10'd13 + plen_x) begin
                    end_item.frame_status = ST_SHORT;
                end else begin
                    end_item.frame_status = ST_OK;
                    if (gps_ok) begin
                        end_item.latitude  = n_lat;
                        end_item.longitude = n_lon;
                    end
                end
            end
            KIND_ACK: begin
                end_item.message_kind = MSG_ACK;
                if (len < 10'd2) begin
                    end_item.frame_status = ST_SHORT;
                end else begin
                    end_item.sequence_res = n_seq;
                end
            end
            default: begin
                end_item.frame_status = ST_UNKNOWN;
            end
        endcase

        // place the end item and mark the last item of the byte
        n_cnt = nc + {1'b0, i_in_item.frame_end};
        if (i_in_item.frame_end) begin
            n_slot[nc] = end_item;
        end
        if (n_cnt != 2'd0) begin
            n_slot[n_cnt - 2'd1].last_of_run = 1'b1;
        end

        // closing byte clears the frame
        if (i_in_item.frame_end) begin
            n_byte_pos   = 9'd0;
            n_kind       = KIND_NONE;
            n_seq        = 8'd0;
            n_count      = 8'd0;
            n_plen       = 8'd0;
            n_residue    = 4'd0;
            n_res_bits   = 3'd0;
            n_chars_done = 8'd0;
            n_gps_flag   = 1'b0;
            n_lat        = 32'd0;
            n_lon        = 32'd0;
            n_count_err  = 1'b0;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= 9'd0;
            r_kind       <= KIND_NONE;
            r_seq        <= 8'd0;
            r_count      <= 8'd0;
            r_plen       <= 8'd0;
            r_residue    <= 4'd0;
            r_res_bits   <= 3'd0;
            r_chars_done <= 8'd0;
            r_gps_flag   <= 1'b0;
            r_lat        <= 32'd0;
            r_lon        <= 32'd0;
            r_count_err  <= 1'b0;
        end else if (accept) begin
            r_byte_pos   <= n_byte_pos;
            r_kind       <= n_kind;
            r_seq        <= n_seq;
            r_count      <= n_count;
            r_plen       <= n_plen;
            r_residue    <= n_residue;
            r_res_bits   <= n_res_bits;
            r_chars_done <= n_chars_done;
            r_gps_flag   <= n_gps_flag;
            r_lat        <= n_lat;
            r_lon        <= n_lon;
            r_count_err  <= n_count_err;
        end
    end

    // result item count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // result payload: load on accept, shift down on each taken item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i] <= n_slot[i];
            end
        end else if (pop) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
                r_slot[i] <= r_slot[i + 1];
            end
        end
    end

endmodule

>>> tb/sv/tfp6_tb_pkg.sv
// ---------------------------------------------------------------------------
// tfp6_tb_pkg
// Scoreboard for the 6-bit text frame parser: it tracks the frame state of
// every accepted byte, predicts the character and end-of-frame items it
// causes, and compares each result item of the block against them in order.
// ---------------------------------------------------------------------------
package tfp6_tb_pkg;

    import tfp6_pkg::*;

    class frame_scoreboard;

        // results still to come from the block, oldest first
        t_out_item   pending_results[$];
        int          failures;

        // frame state as seen by the predictor
        logic [8:0]  byte_pos;
        t_kind       kind;
        logic [7:0]  seq_held;
        logic [7:0]  count_held;
        logic [7:0]  plen_held;
        logic [7:0]  chars_done;
        logic [3:0]  residue;
        logic [2:0]  residue_n;
        logic        gps_flag;
        logic [31:0] lat_held;
        logic [31:0] lon_held;
        logic        too_many;

        function new();
            failures = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos   = '0;
            kind       = KIND_NONE;
            seq_held   = '0;
            count_held = '0;
            plen_held  = '0;
            chars_done = '0;
            residue    = '0;
            residue_n  = '0;
            gps_flag   = 1'b0;
            lat_held   = '0;
            lon_held   = '0;
            too_many   = 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // predict the items caused by one accepted byte
        function void note_byte(t_in_item item);
            t_out_item   run [SLOTS];
            t_out_item   res;
            logic [7:0]  b;
            logic [11:0] acc;
            int          p, plen, len, nb, k, n;
            b    = item.byte_value;
            p    = byte_pos;
            plen = plen_held;
            n    = 0;

            // header, packed characters and gps fields by position
            if (p == 0) begin
                kind = (b == TYPE_TEXT) ? KIND_TEXT : (b == TYPE_ACK) ? KIND_ACK : KIND_UNKNOWN;
            end else if (kind == KIND_ACK) begin
                if (p == 1) seq_held = b;
            end else if (kind == KIND_TEXT) begin
                if (p == 1) begin
                    seq_held = b;
                end else if (p == 2) begin
                    count_held = b;
                    too_many   = (b > MAX_CHARS);
                end else if (p == 3) begin
                    plen_held = b;
                end else if (p < 4 + plen) begin
                    if (!too_many) begin
                        acc = {residue, b};
                        nb  = residue_n + 8;
                        while (nb >= 6 && chars_done < count_held) begin
                            res               = '0;
                            res.item_kind     = RES_CHAR;
                            res.char_code     = 6'((acc >> (nb - 6)) & CODE_MASK);
                            res.char_position = chars_done[5:0];
                            res.message_kind  = MSG_TEXT;
                            res.sequence_res  = seq_held;
                            res.char_total    = count_held;
                            run[n] = res;
                            n++;
                            chars_done++;
                            nb -= 6;
                        end
                        if (nb < 6) begin
                            residue   = 4'(acc & ((12'd1 << nb) - 12'd1));
                            residue_n = 3'(nb);
                        end else begin
                            residue   = '0;
                            residue_n = '0;
                        end
                    end
                end else if (p == 4 + plen) begin
                    gps_flag = (b != 8'd0);
                end else if (p < 13 + plen) begin
                    k = p - (5 + plen);
                    if (k < 4)
                        lat_held = lat_held | (32'(b) << (8 * k));
                    else
                        lon_held = lon_held | (32'(b) << (8 * (k - 4)));
                end
            end

            if (byte_pos != 9'd511) byte_pos++;

            // end-of-frame item with status precedence
            if (item.frame_end) begin
                len              = p + 1;
                res              = '0;
                res.item_kind    = RES_END;
                res.frame_status = ST_OK;
                res.message_kind = MSG_TEXT;
                if (kind == KIND_TEXT) begin
                    if (len >= 2) res.sequence_res = seq_held;
                    if (len >= 3) res.char_total = count_held;
                    if (len >= 5 + plen && len >= 4) res.gps_present = gps_flag;
                    if (len < 4 || len < 5 + plen)
                        res.frame_status = ST_SHORT;
                    else if (too_many)
                        res.frame_status = ST_COUNT_LARGE;
                    else if (chars_done < count_held)
                        res.frame_status = ST_PACKED_SHORT;
                    else if (gps_flag && len < 13 + plen)
                        res.frame_status = ST_SHORT;
                    if (res.frame_status == ST_OK && res.gps_present) begin
                        res.latitude  = lat_held;
                        res.longitude = lon_held;
                    end
                end else if (kind == KIND_ACK) begin
                    res.message_kind = MSG_ACK;
                    if (len < 2)
                        res.frame_status = ST_SHORT;
                    else
                        res.sequence_res = seq_held;
                end else begin
                    res.frame_status = ST_UNKNOWN;
                end
                run[n] = res;
                n++;
                clear_frame();
            end

            // flag the final item of this byte and queue them all
            if (n > 0) run[n - 1].last_of_run = 1'b1;
            for (int i = 0; i < n; i++) pending_results.push_back(run[i]);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        // compare one result item with the oldest prediction
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: 0x%h", got);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            check_field("item_kind", want.item_kind, got.item_kind);
            check_field("char_code", want.char_code, got.char_code);
            check_field("char_position", want.char_position, got.char_position);
            check_field("frame_status", want.frame_status, got.frame_status);
            check_field("message_kind", want.message_kind, got.message_kind);
            check_field("sequence_res", want.sequence_res, got.sequence_res);
            check_field("char_total", want.char_total, got.char_total);
            check_field("gps_present", want.gps_present, got.gps_present);
            check_field("latitude", want.latitude, got.latitude);
            check_field("longitude", want.longitude, got.longitude);
            check_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

    endclass

endpackage

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives whole frames into the 6-bit text frame parser byte by byte: a few
// hand-built frames first, then random text, ack and unknown-type frames,
// many of them truncated or malformed. Both handshakes idle at random, and
// every result item is checked against the scoreboard's prediction.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tfp6_pkg::*;
    import tfp6_tb_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 100;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    frame_scoreboard frames_sb = new();
    logic [7:0]      frame_bytes[$];
    logic            in_quiet;
    int              cycle_count;

    text_frame_parser_6bit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // mostly short idle gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else return $urandom_range(4, 25);
    endfunction

    // present one byte and wait for it to be taken
    task automatic send_byte(input logic [7:0] value, input logic last);
        t_in_item item;
        int       gap;
        item.byte_value = value;
        item.frame_end  = last;
        gap = in_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        frames_sb.note_byte(item);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // text frame with the given header fields and random content
    task automatic build_text(input int count, input int plen, input logic gps_on,
                              input int extra);
        frame_bytes.delete();
        frame_bytes.push_back(TYPE_TEXT);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'(count));
        frame_bytes.push_back(8'(plen));
        repeat (plen) frame_bytes.push_back(8'($urandom));
        if (gps_on) begin
            frame_bytes.push_back(8'($urandom_range(1, 255)));
            repeat (8) frame_bytes.push_back(8'($urandom));
        end else begin
            frame_bytes.push_back(8'h00);
        end
        repeat (extra) frame_bytes.push_back(8'($urandom));
    endtask

    // result side stall: free stretches broken by random holds
    initial begin : out_stall_gen
        int n;
        i_out_stall <= 1'b0;
        forever begin
            n = $urandom_range(1, 40);
            repeat (n) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // check every result item taken from the block
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) frames_sb.check_result(o_out_item);
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("** text_frame_parser_6bit: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int         sent, choice, count, plen, need, cut, len;
        logic [7:0] t;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        in_quiet = 1'b0;
        sent     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unknown type, one-byte ack, normal ack
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes = '{TYPE_ACK};
        send_frame();
        frame_bytes = '{TYPE_ACK, 8'hA5};
        send_frame();
        // count just above the limit
        frame_bytes = '{TYPE_TEXT, 8'hAA, 8'd51, 8'h00, 8'h00};
        send_frame();
        // frame cut on a byte that completes two codes
        frame_bytes = '{TYPE_TEXT, 8'h3C, 8'h04, 8'h03, 8'hFF, 8'h00, 8'hC3};
        send_frame();
        // gps with extreme coordinates
        frame_bytes = '{TYPE_TEXT, 8'h80, 8'h00, 8'h00, 8'h01,
                        8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        send_frame();

        // random frames, mostly well formed
        while (sent < RANDOM_BYTES) begin
            choice   = $urandom_range(0, 99);
            in_quiet = ($urandom_range(0, 3) == 0);
            count    = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 50)
                                                   : $urandom_range(0, 12);
            need     = (count * 6 + 7) / 8;
            if (choice < 55) begin
                plen = need + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
                build_text(count, plen, 1'($urandom_range(0, 1)),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
            end else if (choice < 65) begin
                // truncated anywhere
                build_text($urandom_range(0, 12), 0, 1'($urandom_range(0, 1)), 0);
                frame_bytes.delete();
                count = $urandom_range(0, 12);
                build_text(count, (count * 6 + 7) / 8, 1'($urandom_range(0, 1)), 0);
                cut = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end else if (choice < 72) begin
                build_text($urandom_range(51, 255), $urandom_range(0, 6),
                           1'($urandom_range(0, 1)), 0);
            end else if (choice < 80) begin
                count = $urandom_range(2, 20);
                build_text(count, $urandom_range(0, (count * 6 + 7) / 8 - 1),
                           1'($urandom_range(0, 1)), 0);
            end else if (choice < 90) begin
                frame_bytes = '{TYPE_ACK};
                if ($urandom_range(0, 4) != 0) frame_bytes.push_back(8'($urandom));
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
            end else begin
                do t = 8'($urandom); while (t == TYPE_TEXT || t == TYPE_ACK);
                frame_bytes = '{t};
                len = $urandom_range(0, 3);
                repeat (len) frame_bytes.push_back(8'($urandom));
            end
            sent += frame_bytes.size();
            send_frame();
        end

        // frame with a long tail that is ignored, sent back to back
        in_quiet = 1'b1;
        build_text(0, 0, 1'b0, 20);
        send_frame();

        // drain
        i_in_valid <= 1'b0;
        while (frames_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (frames_sb.failures == 0)
            $display("** text_frame_parser_6bit: PASSED **");
        else
            $display("** text_frame_parser_6bit: FAILED **");
        $finish;
    end

endmodule
